// ----- design/ipbc_pkg.sv -----
package ipbc_pkg;

  localparam int unsigned NumLanes   = 3;
  localparam int unsigned StoreDepth = 30;
  localparam int unsigned BaseK      = 0;
  localparam int unsigned BaseR      = 9;
  localparam int unsigned BaseM      = 18;
  localparam int unsigned BaseT      = 27;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } ipbc_op_e;

  typedef logic signed [31:0] ipbc_word_t;

  typedef struct packed {
    logic              opcode;
    logic [4:0]        coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] position_0;
    logic signed [31:0] position_1;
    logic signed [31:0] position_2;
    logic signed [31:0] velocity_0;
    logic signed [31:0] velocity_1;
    logic signed [31:0] velocity_2;
    logic signed [31:0] gravity_0;
    logic signed [31:0] gravity_1;
    logic signed [31:0] gravity_2;
  } ipbc_in_t;

  typedef struct packed {
    logic              status;
    logic signed [31:0] torque_0;
    logic signed [31:0] torque_1;
    logic signed [31:0] torque_2;
    logic signed [31:0] energy;
    logic signed [31:0] energy_rate;
  } ipbc_out_t;

  // per-lane result handed to the merge stage
  typedef struct packed {
    logic signed [31:0] tau;
    logic signed [48:0] energy;
    logic signed [47:0] rate;
  } ipbc_lane_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/ipbc_lane.sv -----
module ipbc_lane (
  input  logic                   clk_i,
  input  logic                   adv_i,
  input  ipbc_pkg::ipbc_word_t [2:0] e_i,
  input  ipbc_pkg::ipbc_word_t [2:0] v_i,
  input  ipbc_pkg::ipbc_word_t   g_i,
  input  ipbc_pkg::ipbc_word_t [2:0] k_row_i,
  input  ipbc_pkg::ipbc_word_t [2:0] r_row_i,
  input  ipbc_pkg::ipbc_word_t [2:0] m_row_i,
  output ipbc_pkg::ipbc_lane_t   res_o
);

  // stage A: floored products of the row with e and v
  logic signed [47:0] pk_q [3];
  logic signed [47:0] pr_q [3];
  logic signed [47:0] pm_q [3];
  logic signed [31:0] ea_q, va_q, ga_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < 3; j++) begin
        pk_q[j] <= 48'((64'($signed(k_row_i[j])) * 64'($signed(e_i[j]))) >>> 16);
        pr_q[j] <= 48'((64'($signed(r_row_i[j])) * 64'($signed(v_i[j]))) >>> 16);
        pm_q[j] <= 48'((64'($signed(m_row_i[j])) * 64'($signed(v_i[j]))) >>> 16);
      end
      ea_q <= e_i[0];
      va_q <= v_i[0];
      ga_q <= g_i;
    end
  end

  // stage B: row sums, torque, saturated row terms
  logic signed [49:0] rk_d, rr_d, rm_d;
  logic signed [51:0] tau_d;
  logic signed [31:0] tau_q, sk_q, sr_q, sm_q, eb_q, vb_q;

  always_comb begin
    rk_d  = 50'(pk_q[0]) + 50'(pk_q[1]) + 50'(pk_q[2]);
    rr_d  = 50'(pr_q[0]) + 50'(pr_q[1]) + 50'(pr_q[2]);
    rm_d  = 50'(pm_q[0]) + 50'(pm_q[1]) + 50'(pm_q[2]);
    tau_d = 52'(ga_q) - 52'(rk_d) - 52'(rr_d);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tau_q <= ipbc_pkg::sat32(64'(tau_d));
      sk_q  <= ipbc_pkg::sat32(64'(rk_d));
      sr_q  <= ipbc_pkg::sat32(64'(rr_d));
      sm_q  <= ipbc_pkg::sat32(64'(rm_d));
      eb_q  <= ea_q;
      vb_q  <= va_q;
    end
  end

  // stage C: energy and dissipation products
  logic signed [63:0] pek_d, pvm_d, pvr_d;

  always_comb begin
    pek_d = 64'(eb_q) * 64'(sk_q);
    pvm_d = 64'(vb_q) * 64'(sm_q);
    pvr_d = 64'(vb_q) * 64'(sr_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o.tau    <= tau_q;
      res_o.energy <= 49'(pek_d >>> 17) + 49'(pvm_d >>> 17);
      res_o.rate   <= 48'(pvr_d >>> 16);
    end
  end

endmodule

// ----- design/ipbc_merge.sv -----
module ipbc_merge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  logic                   status_i,
  input  ipbc_pkg::ipbc_lane_t [2:0] lane_i,
  output logic                   valid_o,
  output ipbc_pkg::ipbc_out_t    data_o
);

  logic signed [50:0] esum_d, rsum_d;
  logic               valid_q;
  ipbc_pkg::ipbc_out_t data_q;

  always_comb begin
    esum_d = 51'(lane_i[0].energy) + 51'(lane_i[1].energy) + 51'(lane_i[2].energy);
    rsum_d = -(51'(lane_i[0].rate) + 51'(lane_i[1].rate) + 51'(lane_i[2].rate));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q.status      <= status_i;
      data_q.torque_0    <= lane_i[0].tau;
      data_q.torque_1    <= lane_i[1].tau;
      data_q.torque_2    <= lane_i[2].tau;
      data_q.energy      <= ipbc_pkg::sat32(64'(esum_d));
      data_q.energy_rate <= ipbc_pkg::sat32(64'(rsum_d));
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && data_q.status == ipbc_pkg::OP_LOAD |->
      data_q.torque_0 == '0 && data_q.torque_1 == '0 && data_q.torque_2 == '0 &&
      data_q.energy == '0 && data_q.energy_rate == '0)
    else $error("load word carries nonzero results");

  a_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(valid_q))
    else $error("output valid is unknown");

  a_word_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !$isunknown(data_q))
    else $error("output word is unknown while valid");

endmodule

// ----- design/ida_pbc_torque_and_energy_top.sv -----
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_ready_o   in_data_i  (ipbc_in_t)
// out      output     out_valid_o / out_ready_i out_data_o (ipbc_out_t)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (dof_in_use)
//
// One word per cycle sustained while the output is not stalled.
// Three row lanes each own one 32x32 multiplier per coefficient product.
// Reset clears the coefficient store, sets dof_in_use to 3, empties the pipe.
// A stall at the output freezes the whole pipe; in_ready_o drops with it.
// The config port is always ready.
module ida_pbc_torque_and_energy_top #(
  parameter int unsigned MAX_JOINTS = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ipbc_pkg::ipbc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ipbc_pkg::ipbc_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);

  // the store layout caps the active joints at three
  localparam logic [1:0] JointCap = (MAX_JOINTS > 3) ? 2'd3 : 2'(MAX_JOINTS);

  logic       adv;
  logic       in_acc;
  logic [1:0] dof_q;
  logic [1:0] n_act;
  logic signed [31:0] store_q [ipbc_pkg::StoreDepth];

  // advance the whole pipe whenever the output slot frees up
  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign n_act       = (dof_q > JointCap) ? JointCap : dof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dof_q <= 2'd3;
    end else if (cfg_valid_i) begin
      dof_q <= cfg_data_i;
    end
  end

  // write one coefficient word on a load; drop indexes past the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ipbc_pkg::StoreDepth; k++) store_q[k] <= '0;
    end else if (in_acc && in_data_i.opcode == ipbc_pkg::OP_LOAD &&
                 32'(in_data_i.coeff_index) < ipbc_pkg::StoreDepth) begin
      store_q[in_data_i.coeff_index] <= in_data_i.coeff_value;
    end
  end

  // front stage: position error, masking of unused joints and of loads
  logic signed [31:0] q_in [3];
  logic signed [31:0] v_in [3];
  logic signed [31:0] g_in [3];
  ipbc_pkg::ipbc_word_t [2:0] e_d, v_d, g_d;
  ipbc_pkg::ipbc_word_t [2:0] e_q, v_q, g_q;
  logic               s1_valid_q, s1_op_q;

  always_comb begin
    q_in[0] = in_data_i.position_0;
    q_in[1] = in_data_i.position_1;
    q_in[2] = in_data_i.position_2;
    v_in[0] = in_data_i.velocity_0;
    v_in[1] = in_data_i.velocity_1;
    v_in[2] = in_data_i.velocity_2;
    g_in[0] = in_data_i.gravity_0;
    g_in[1] = in_data_i.gravity_1;
    g_in[2] = in_data_i.gravity_2;
    for (int j = 0; j < 3; j++) begin
      if (in_data_i.opcode == ipbc_pkg::OP_COMPUTE && 2'(j) < n_act) begin
        e_d[j] = ipbc_pkg::sat32(64'(q_in[j]) - 64'(store_q[ipbc_pkg::BaseT + j]));
        v_d[j] = v_in[j];
        g_d[j] = g_in[j];
      end else begin
        e_d[j] = '0;
        v_d[j] = '0;
        g_d[j] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q     <= e_d;
      v_q     <= v_d;
      g_q     <= g_d;
      s1_op_q <= in_data_i.opcode;
    end
  end

  // valid and status travel beside the lanes
  logic [2:0] vpipe_q;
  logic [2:0] spipe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      vpipe_q    <= '0;
    end else if (adv) begin
      s1_valid_q <= in_acc;
      vpipe_q    <= {vpipe_q[1:0], s1_valid_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spipe_q <= {spipe_q[1:0], s1_op_q};
    end
  end

  ipbc_pkg::ipbc_lane_t [2:0] lane_res;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ipbc_pkg::ipbc_word_t [2:0] k_row, r_row, m_row;
    ipbc_pkg::ipbc_word_t [2:0] e_rot, v_rot;

    always_comb begin
      // zero the rows of an unused joint so its torque stays zero
      for (int j = 0; j < 3; j++) begin
        if (2'(i) < n_act) begin
          k_row[j] = store_q[ipbc_pkg::BaseK + 3 * i + j];
          r_row[j] = store_q[ipbc_pkg::BaseR + 3 * i + j];
          m_row[j] = store_q[ipbc_pkg::BaseM + 3 * i + j];
        end else begin
          k_row[j] = '0;
          r_row[j] = '0;
          m_row[j] = '0;
        end
      end
      // element 0 of the rotated vectors is this lane's own joint
      for (int j = 0; j < 3; j++) begin
        e_rot[j] = e_q[(i + j) % 3];
        v_rot[j] = v_q[(i + j) % 3];
      end
    end

    // rotate the row the same way so products still pair by column
    ipbc_pkg::ipbc_word_t [2:0] k_rot, r_rot, m_rot;
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        k_rot[j] = k_row[(i + j) % 3];
        r_rot[j] = r_row[(i + j) % 3];
        m_rot[j] = m_row[(i + j) % 3];
      end
    end

    ipbc_lane u_lane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .e_i     (e_rot),
      .v_i     (v_rot),
      .g_i     (g_q[i]),
      .k_row_i (k_rot),
      .r_row_i (r_rot),
      .m_row_i (m_rot),
      .res_o   (lane_res[i])
    );
  end

  ipbc_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (vpipe_q[2]),
    .status_i (spipe_q[2]),
    .lane_i   (lane_res),
    .valid_o  (out_valid_o),
    .data_o   (out_data_o)
  );

  a_load_operands_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_op_q == ipbc_pkg::OP_LOAD |->
      e_q == '0 && v_q == '0 && g_q == '0)
    else $error("load word entered lanes with operands");

  a_stall_freezes_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vpipe_q) && $stable(s1_valid_q))
    else $error("pipe moved during a stall");

  a_out_follows_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o == $past(vpipe_q[2]))
    else $error("output valid lost track of the pipe");

endmodule

// ----- dv/tb_ida_pbc_torque_and_energy_top.sv -----
module tb_ida_pbc_torque_and_energy_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Track the coefficient store and joint count, and hold the torque and
  // energy words that the block still owes us.
  class torque_energy_board;
    ipbc_pkg::ipbc_word_t coeff_store[ipbc_pkg::StoreDepth];
    logic [1:0] joints_cfg;
    ipbc_pkg::ipbc_out_t owed_words[$];
    int         mismatches;

    function new();
      foreach (coeff_store[k]) coeff_store[k] = '0;
      joints_cfg = 2'd3;
      mismatches = 0;
    endfunction

    function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    // Work out the control word for one compute request.
    function automatic ipbc_pkg::ipbc_out_t control_law(ipbc_pkg::ipbc_in_t w);
      ipbc_pkg::ipbc_out_t r;
      longint err[3], vel[3], grav[3], tau[3];
      longint rk, rr, rm, energy, rate;
      int n;
      r = '0;
      r.status = 1'b1;
      n = (joints_cfg > 3) ? 3 : joints_cfg;
      err[0] = clamp32(longint'(w.position_0) - coeff_store[ipbc_pkg::BaseT]);
      err[1] = clamp32(longint'(w.position_1) - coeff_store[ipbc_pkg::BaseT + 1]);
      err[2] = clamp32(longint'(w.position_2) - coeff_store[ipbc_pkg::BaseT + 2]);
      vel[0] = w.velocity_0; vel[1] = w.velocity_1; vel[2] = w.velocity_2;
      grav[0] = w.gravity_0; grav[1] = w.gravity_1; grav[2] = w.gravity_2;
      energy = 0;
      rate = 0;
      for (int i = 0; i < 3; i++) tau[i] = 0;
      for (int i = 0; i < n; i++) begin
        rk = 0; rr = 0; rm = 0;
        for (int j = 0; j < n; j++) begin
          rk += (longint'(coeff_store[ipbc_pkg::BaseK + 3*i + j]) * err[j]) >>> 16;
          rr += (longint'(coeff_store[ipbc_pkg::BaseR + 3*i + j]) * vel[j]) >>> 16;
          rm += (longint'(coeff_store[ipbc_pkg::BaseM + 3*i + j]) * vel[j]) >>> 16;
        end
        tau[i] = grav[i] - rk - rr;
        energy += (err[i] * clamp32(rk)) >>> 17;
        energy += (vel[i] * clamp32(rm)) >>> 17;
        rate -= (vel[i] * clamp32(rr)) >>> 16;
      end
      r.torque_0 = 32'(clamp32(tau[0]));
      r.torque_1 = 32'(clamp32(tau[1]));
      r.torque_2 = 32'(clamp32(tau[2]));
      r.energy = 32'(clamp32(energy));
      r.energy_rate = 32'(clamp32(rate));
      return r;
    endfunction

    function void note_request(ipbc_pkg::ipbc_in_t w);
      ipbc_pkg::ipbc_out_t r;
      if (w.opcode == ipbc_pkg::OP_LOAD) begin
        r = '0;
        if (w.coeff_index < ipbc_pkg::StoreDepth) coeff_store[w.coeff_index] = w.coeff_value;
      end else begin
        r = control_law(w);
      end
      owed_words.push_back(r);
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    endfunction

    function void check_word(ipbc_pkg::ipbc_out_t got);
      ipbc_pkg::ipbc_out_t exp_w;
      if (owed_words.size() == 0) begin
        report("unexpected word", 0, got.status);
        return;
      end
      exp_w = owed_words.pop_front();
      if (got.status !== exp_w.status) report("status", exp_w.status, got.status);
      if (got.torque_0 !== exp_w.torque_0) report("torque_0", exp_w.torque_0, got.torque_0);
      if (got.torque_1 !== exp_w.torque_1) report("torque_1", exp_w.torque_1, got.torque_1);
      if (got.torque_2 !== exp_w.torque_2) report("torque_2", exp_w.torque_2, got.torque_2);
      if (got.energy !== exp_w.energy) report("energy", exp_w.energy, got.energy);
      if (got.energy_rate !== exp_w.energy_rate)
        report("energy_rate", exp_w.energy_rate, got.energy_rate);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  ipbc_pkg::ipbc_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  ipbc_pkg::ipbc_out_t out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i = '0;

  torque_energy_board board = new();
  bit no_idle = 1'b0;     // drop all random gaps on both sides
  bit long_hold = 1'b0;   // ask the receiver for one long stall

  always #5 clk_i = ~clk_i;

  ida_pbc_torque_and_energy_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Watch all three channels at the edge; values read here are pre-edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.joints_cfg = cfg_data_i;
      if (in_valid_i && in_ready_o) board.note_request(in_data_i);
      if (out_valid_o && out_ready_i) board.check_word(out_data_o);
    end
  end

  // Receiver: random stalls per word, plus one long hold-off on request.
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        out_ready_i <= 1'b0;
        @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic ipbc_pkg::ipbc_word_t pick_word(bit mostly_small);
    int sel;
    sel = $urandom_range(0, mostly_small ? 9 : 5);
    case (sel)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    endcase
  endfunction

  task automatic send_word(ipbc_pkg::ipbc_in_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_coeff(logic [4:0] idx, ipbc_pkg::ipbc_word_t val);
    ipbc_pkg::ipbc_in_t w;
    w = '0;
    w.opcode = ipbc_pkg::OP_LOAD;
    w.coeff_index = idx;
    w.coeff_value = val;
    send_word(w);
  endtask

  task automatic compute_all(ipbc_pkg::ipbc_word_t q, ipbc_pkg::ipbc_word_t v,
                             ipbc_pkg::ipbc_word_t g);
    ipbc_pkg::ipbc_in_t w;
    w = '0;
    w.opcode = ipbc_pkg::OP_COMPUTE;
    w.position_0 = q; w.position_1 = q; w.position_2 = q;
    w.velocity_0 = v; w.velocity_1 = v; w.velocity_2 = v;
    w.gravity_0 = g; w.gravity_1 = g; w.gravity_2 = g;
    send_word(w);
  endtask

  // Hold the sender until every owed word is back, then let the pipe drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.owed_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_joints(logic [1:0] n);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_burst(int count);
    ipbc_pkg::ipbc_in_t w;
    for (int k = 0; k < count; k++) begin
      w = '0;
      // Stuff random bits into the unused fields too; the block must ignore them.
      w.coeff_index = $urandom_range(0, 31);
      w.coeff_value = pick_word(1'b1);
      w.position_0 = pick_word(1'b1);
      w.position_1 = pick_word(1'b1);
      w.position_2 = pick_word(1'b1);
      w.velocity_0 = pick_word(1'b1);
      w.velocity_1 = pick_word(1'b1);
      w.velocity_2 = pick_word(1'b1);
      w.gravity_0 = pick_word(1'b1);
      w.gravity_1 = pick_word(1'b1);
      w.gravity_2 = pick_word(1'b1);
      w.opcode = ($urandom_range(0, 9) < 4) ? ipbc_pkg::OP_LOAD : ipbc_pkg::OP_COMPUTE;
      send_word(w);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: diagonal gains, store extremes, out-of-range indexes, then
    // computes at the field extremes, with all three joints active.
    set_joints(2'd3);
    load_coeff(5'd0, 32'sh10000);
    load_coeff(5'd4, 32'sh20000);
    load_coeff(5'd8, 32'sh7fffffff);
    load_coeff(5'd9, 32'sh8000);
    load_coeff(5'd13, 32'sh80000000);
    load_coeff(5'd17, -32'sh10000);
    load_coeff(5'd18, 32'sh10000);
    load_coeff(5'd22, 32'sh7fffffff);
    load_coeff(5'd26, 32'sh80000000);
    load_coeff(5'd27, 32'sh7fffffff);
    load_coeff(5'd28, 32'sh80000000);
    load_coeff(5'd29, 32'sh10000);
    load_coeff(5'd30, 32'sh12345);
    load_coeff(5'd31, -32'sh1);
    compute_all(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    compute_all(32'sh80000000, 32'sh80000000, 32'sh80000000);
    compute_all(32'sh0, 32'sh0, 32'sh0);
    compute_all(32'sh18000, -32'sh8000, 32'sh4000);

    // Random phases across joint counts, zero joints included.
    set_joints(2'd1);
    random_burst(260);
    set_joints(2'd2);
    random_burst(100);
    long_hold = 1'b1;     // receiver stalls long while we keep offering words
    random_burst(160);
    set_joints(2'd0);
    random_burst(200);
    set_joints(2'd3);
    no_idle = 1'b1;
    random_burst(200);
    no_idle = 1'b0;
    random_burst(160);
    set_joints(2'd2);
    random_burst(200);

    drain();
    if (board.mismatches == 0 && board.owed_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
